### hdl/prup_pkg.sv
`timescale 1ns / 1ps

package prup_pkg;

  // Input command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SCALE     = 2'd0;
  localparam logic [1:0] REG_ROW_WIDTH = 2'd1;
  localparam logic [1:0] REG_ROW_COUNT = 2'd2;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 13;
  localparam int PIX_W  = 24;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } res_flags_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    res_flags_t flags;
  } pix_item_t;

  // Zero maps to one, anything above the limit maps to the limit
  function automatic logic [31:0] clamp_limit(input logic [31:0] v, input logic [31:0] lim);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/prup_line_buf.sv
`timescale 1ns / 1ps

module prup_line_buf #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [prup_pkg::PIX_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [prup_pkg::PIX_W-1:0] rd_data
);

  logic [prup_pkg::PIX_W-1:0] mem [DEPTH];
  logic [prup_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/prup_seq.sv
`timescale 1ns / 1ps

module prup_seq #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_SCALE  = 99,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic                         in_cmd,
  input  logic [$clog2(MAX_SCALE+1)-1:0]  scale,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
  output logic                         wr_en,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr,
  output logic                         rd_en,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr,
  output logic                         rd_vld,
  output prup_pkg::res_flags_t         rd_flags
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [AW-1:0] load_col_r, load_col_nxt;
  logic [AW-1:0] out_col_r, out_col_nxt;
  logic          row_loaded_r, row_loaded_nxt;
  logic [SW-1:0] copy_r, copy_nxt;
  logic [SW-1:0] rep_r, rep_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic          rd_vld_r;
  prup_pkg::res_flags_t flags_r, flags_nxt;

  logic do_load, do_req;
  logic lc_last, copy_last, col_last, rep_last, row_last;

  // "reached or passed" compares, so a shrunk limit finishes the step at once
  assign lc_last   = (WW'(load_col_r) + WW'(1)) >= width;
  assign col_last  = (WW'(out_col_r) + WW'(1)) >= width;
  assign copy_last = (copy_r + SW'(1)) >= scale;
  assign rep_last  = (rep_r + SW'(1)) >= scale;
  assign row_last  = (row_r + HW'(1)) >= height;

  assign do_load = in_fire && (in_cmd == prup_pkg::CMD_LOAD) && !row_loaded_r;
  assign do_req  = in_fire && (in_cmd == prup_pkg::CMD_REQUEST) && row_loaded_r;

  always_comb begin
    load_col_nxt   = load_col_r;
    out_col_nxt    = out_col_r;
    row_loaded_nxt = row_loaded_r;
    copy_nxt       = copy_r;
    rep_nxt        = rep_r;
    row_nxt        = row_r;
    flags_nxt      = '0;

    if (do_load) begin
      if (lc_last) begin
        load_col_nxt   = '0;
        row_loaded_nxt = 1'b1;
      end else begin
        load_col_nxt = load_col_r + AW'(1);
      end
    end

    if (do_req) begin
      if (copy_last) begin
        copy_nxt = '0;
        if (col_last) begin
          out_col_nxt       = '0;
          flags_nxt.row_end = 1'b1;
          if (rep_last) begin
            rep_nxt        = '0;
            row_loaded_nxt = 1'b0;
            if (row_last) begin
              row_nxt             = '0;
              flags_nxt.frame_end = 1'b1;
            end else begin
              row_nxt = row_r + HW'(1);
            end
          end else begin
            rep_nxt = rep_r + SW'(1);
          end
        end else begin
          out_col_nxt = out_col_r + AW'(1);
        end
      end else begin
        copy_nxt = copy_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_col_r   <= '0;
      out_col_r    <= '0;
      row_loaded_r <= 1'b0;
      copy_r       <= '0;
      rep_r        <= '0;
      row_r        <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      load_col_r   <= load_col_nxt;
      out_col_r    <= out_col_nxt;
      row_loaded_r <= row_loaded_nxt;
      copy_r       <= copy_nxt;
      rep_r        <= rep_nxt;
      row_r        <= row_nxt;
      rd_vld_r     <= do_req;
    end
  end

  // flags travel alongside the buffer read
  always_ff @(posedge clk) begin
    if (do_req) begin
      flags_r <= flags_nxt;
    end
  end

  assign wr_en    = do_load;
  assign wr_addr  = load_col_r;
  assign rd_en    = do_req;
  assign rd_addr  = out_col_r;
  assign rd_vld   = rd_vld_r;
  assign rd_flags = flags_r;

endmodule

### hdl/prup_out_fifo.sv
`timescale 1ns / 1ps

module prup_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  prup_pkg::pix_item_t push_data,
  input  logic                pop,
  output logic                head_vld,
  output prup_pkg::pix_item_t head,
  output logic [1:0]          count
);

  localparam int DEPTH = 3;

  prup_pkg::pix_item_t ent [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign do_pop = pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == 2'(DEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == 2'(DEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr_r] <= push_data;
    end
  end

  assign head_vld = (count_r != 2'd0);
  assign head     = ent[rd_ptr_r];
  assign count    = count_r;

endmodule

### hdl/pixel_replication_upscaler.sv
`timescale 1ns / 1ps

// Integer nearest-neighbor upscaler for 24-bit pixels.
// Input channel (in_valid/in_stall): in_cmd = load stores one pixel into the
// line buffer; in_cmd = request asks for the next output pixel of the
// buffered row. Each stored pixel is repeated scale times across the row and
// the row is replayed scale times, then the buffer takes the next row. Loads
// while a row is buffered are dropped; requests with no row give no item.
// Output channel (out_valid/out_stall): one item per served request, with
// out_row_end and out_frame_end marking row and frame ends.
// Config port (cfg_we/cfg_addr/cfg_wdata): scale, row_width, row_count;
// write only while idle.
// A served request is registered in the line buffer read register, then
// written to the output queue, whose head drives the outputs.
// Throughput: one item per cycle while in_stall is low, set by the single
// line buffer access per item. A three-entry output queue keeps input flowing
// while the receiver stalls; in_stall rises only when the queue and the read
// in flight fill it.
// Reset (synchronous, rst_n low) clears counters and the queue and sets the
// config registers to 1; the line buffer is not cleared.
module pixel_replication_upscaler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_SCALE  = 99,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [7:0]                   in_blue,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_red,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_blue,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_red,
  output logic                         out_row_end,
  output logic                         out_frame_end,
  input  logic                         cfg_we,
  input  logic [prup_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [prup_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [SW-1:0] scale_r;
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;

  // Registers hold the clamped value; only the clamped value is ever used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SW'(1);
      width_r  <= WW'(1);
      height_r <= HW'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        prup_pkg::REG_SCALE: begin
          scale_r <= SW'(prup_pkg::clamp_limit({25'd0, cfg_wdata[6:0]}, 32'(MAX_SCALE)));
        end
        prup_pkg::REG_ROW_WIDTH: begin
          width_r <= WW'(prup_pkg::clamp_limit({19'd0, cfg_wdata}, 32'(MAX_WIDTH)));
        end
        prup_pkg::REG_ROW_COUNT: begin
          height_r <= HW'(prup_pkg::clamp_limit({19'd0, cfg_wdata}, 32'(MAX_HEIGHT)));
        end
        default: begin
        end
      endcase
    end
  end

  logic                 in_fire;
  logic                 wr_en, rd_en, rd_vld;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [prup_pkg::PIX_W-1:0] rd_data;
  prup_pkg::res_flags_t rd_flags;
  prup_pkg::pix_item_t  push_item, head;
  logic [1:0]           q_count;
  logic                 head_vld;

  assign in_stall = ({1'b0, q_count} + {2'b00, rd_vld}) > 3'd2;
  assign in_fire  = in_valid && !in_stall;

  prup_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_SCALE  (MAX_SCALE),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_cmd   (in_cmd),
    .scale    (scale_r),
    .width    (width_r),
    .height   (height_r),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_vld   (rd_vld),
    .rd_flags (rd_flags)
  );

  prup_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign push_item.red   = rd_data[23:16];
  assign push_item.green = rd_data[15:8];
  assign push_item.blue  = rd_data[7:0];
  assign push_item.flags = rd_flags;

  prup_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_vld),
    .push_data (push_item),
    .pop       (!out_stall),
    .head_vld  (head_vld),
    .head      (head),
    .count     (q_count)
  );

  assign out_valid     = head_vld;
  assign out_blue      = head.blue;
  assign out_green     = head.green;
  assign out_red       = head.red;
  assign out_row_end   = head.flags.row_end;
  assign out_frame_end = head.flags.frame_end;

endmodule

### dv/tb_pixel_replication_upscaler.sv
`timescale 1ns / 1ps

module tb_pixel_replication_upscaler;

  localparam int MAX_W        = 4096;
  localparam int MAX_S        = 99;
  localparam int MAX_H        = 4096;
  localparam int DRAIN_CYCLES = 4;

  class upscale_checker;
    logic [6:0]  scale_reg;
    logic [12:0] width_reg;
    logic [12:0] count_reg;
    logic [23:0] line_buf [MAX_W];
    bit          filled [MAX_W];
    int          load_col;
    int          out_col;
    int          copy_cnt;
    int          rep_cnt;
    int          in_row;
    bit          row_loaded;
    prup_pkg::pix_item_t pixels_due [$];
    int          errors;
    int          loads;
    int          requests;
    int          checked;
    int          row_ends;
    int          frame_ends;
    int          settings;

    function new();
      scale_reg  = 7'd1;
      width_reg  = 13'd1;
      count_reg  = 13'd1;
      load_col   = 0;
      out_col    = 0;
      copy_cnt   = 0;
      rep_cnt    = 0;
      in_row     = 0;
      row_loaded = 0;
      errors     = 0;
      loads      = 0;
      requests   = 0;
      checked    = 0;
      row_ends   = 0;
      frame_ends = 0;
      settings   = 0;
      foreach (filled[i]) filled[i] = 0;
    endfunction

    function int limit_of(int v, int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void set_reg(logic [prup_pkg::CFG_AW-1:0] idx, logic [prup_pkg::CFG_DW-1:0] val);
      case (idx)
        prup_pkg::REG_SCALE:     scale_reg = val[6:0];
        prup_pkg::REG_ROW_WIDTH: width_reg = val;
        prup_pkg::REG_ROW_COUNT: count_reg = val;
        default: ;
      endcase
    endfunction

    // entries from column 0 up that hold a loaded pixel
    function int written_prefix();
      int n;
      n = 0;
      while (n < MAX_W && filled[n]) n++;
      return n;
    endfunction

    function void take_item(logic cmd, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int        s;
      int        w;
      int        h;
      prup_pkg::pix_item_t px;
      s = limit_of(int'(scale_reg), MAX_S);
      w = limit_of(int'(width_reg), MAX_W);
      h = limit_of(int'(count_reg), MAX_H);
      if (cmd == prup_pkg::CMD_LOAD) begin
        if (row_loaded) return;
        loads++;
        line_buf[load_col] = {r, g, b};
        filled[load_col] = 1;
        if (load_col + 1 >= w) begin
          load_col   = 0;
          row_loaded = 1;
        end else begin
          load_col++;
        end
        return;
      end
      if (!row_loaded) return;
      requests++;
      {px.red, px.green, px.blue} = line_buf[out_col];
      px.flags = '0;
      // every limit is "reached or passed" so a shrunk register ends the step at once
      if (copy_cnt + 1 >= s) begin
        copy_cnt = 0;
        if (out_col + 1 >= w) begin
          out_col = 0;
          px.flags.row_end = 1'b1;
          if (rep_cnt + 1 >= s) begin
            rep_cnt    = 0;
            row_loaded = 0;
            if (in_row + 1 >= h) begin
              in_row = 0;
              px.flags.frame_end = 1'b1;
            end else begin
              in_row++;
            end
          end else begin
            rep_cnt++;
          end
        end else begin
          out_col++;
        end
      end else begin
        copy_cnt++;
      end
      pixels_due.push_back(px);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(prup_pkg::pix_item_t got);
      prup_pkg::pix_item_t want;
      if (pixels_due.size() == 0) begin
        $display("%0t: output pixel with none due, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      checked++;
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("row_end", 8'(want.flags.row_end), 8'(got.flags.row_end));
      compare_field("frame_end", 8'(want.flags.frame_end), 8'(got.flags.frame_end));
      if (want.flags.row_end) row_ends++;
      if (want.flags.frame_end) frame_ends++;
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic                in_cmd    = prup_pkg::CMD_LOAD;
  logic [7:0]          in_blue   = 8'd0;
  logic [7:0]          in_green  = 8'd0;
  logic [7:0]          in_red    = 8'd0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_blue;
  logic [7:0]          out_green;
  logic [7:0]          out_red;
  logic                out_row_end;
  logic                out_frame_end;
  logic                cfg_we    = 1'b0;
  logic [prup_pkg::CFG_AW-1:0] cfg_addr  = '0;
  logic [prup_pkg::CFG_DW-1:0] cfg_wdata = '0;

  upscale_checker sb;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_request = 0;

  pixel_replication_upscaler #(
    .MAX_WIDTH  (MAX_W),
    .MAX_SCALE  (MAX_S),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_blue       (in_blue),
    .in_green      (in_green),
    .in_red        (in_red),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: samples pre-edge outputs, then picks the stall for the next cycle
  initial begin : rx_proc
    int        hold_left;
    prup_pkg::pix_item_t got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.red             = out_red;
        got.green           = out_green;
        got.blue            = out_blue;
        got.flags.row_end   = out_row_end;
        got.flags.frame_end = out_frame_end;
        sb.check_pixel(got);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  task automatic send_item(logic cmd, logic [23:0] pix);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    {in_red, in_green, in_blue} <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_item(cmd, pix[7:0], pix[15:8], pix[23:16]);
  endtask

  // stop offering and wait until every due pixel is out and the pipe is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [prup_pkg::CFG_AW-1:0] idx, logic [prup_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(logic [12:0] s, logic [12:0] w, logic [12:0] c);
    write_reg(prup_pkg::REG_SCALE, s);
    write_reg(prup_pkg::REG_ROW_WIDTH, w);
    write_reg(prup_pkg::REG_ROW_COUNT, c);
    cfg_we <= 1'b0;
    sb.settings++;
  endtask

  task automatic fill_row();
    while (!sb.row_loaded) send_item(prup_pkg::CMD_LOAD, 24'($urandom()));
  endtask

  task automatic empty_row();
    while (sb.row_loaded) send_item(prup_pkg::CMD_REQUEST, 24'($urandom()));
  endtask

  // mostly whole rows with random pixels, plus stray requests and dropped loads
  task automatic random_group(int budget);
    int          done;
    logic        cmd;
    logic [12:0] s;
    logic [12:0] w;
    settle();
    s      = 13'($urandom());
    s[6:0] = 7'($urandom_range(0, 4));
    w      = 13'($urandom_range(0, 8));
    // a pending row may not be widened past what was ever loaded
    if (sb.row_loaded && w > sb.written_prefix()) w = 13'(sb.written_prefix());
    program_regs(s, w, 13'($urandom_range(0, 4)));
    done = 0;
    while (done < budget) begin
      if (sb.row_loaded) begin
        cmd = ($urandom_range(0, 9) == 0) ? prup_pkg::CMD_LOAD : prup_pkg::CMD_REQUEST;
      end else begin
        cmd = ($urandom_range(0, 9) == 0) ? prup_pkg::CMD_REQUEST : prup_pkg::CMD_LOAD;
      end
      if (sb.row_loaded == (cmd == prup_pkg::CMD_REQUEST)) done++;
      send_item(cmd, 24'($urandom()));
      if ($urandom_range(0, 199) == 0) settle();
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: one pixel per row, one row per frame
    send_item(prup_pkg::CMD_REQUEST, 24'hFFFFFF);  // no row yet, nothing comes back
    send_item(prup_pkg::CMD_LOAD, 24'hFFFFFF);
    send_item(prup_pkg::CMD_LOAD, 24'h000000);     // row pending, dropped
    send_item(prup_pkg::CMD_REQUEST, 24'h000000);

    // all-zero register fields read as one
    settle();
    program_regs(13'h1F80, 13'h0000, 13'h0000);
    send_item(prup_pkg::CMD_LOAD, 24'h55AA55);
    send_item(prup_pkg::CMD_REQUEST, 24'hAA55AA);

    // shrink scale and width part way through a row
    settle();
    program_regs(13'd2, 13'd3, 13'd2);
    send_item(prup_pkg::CMD_LOAD, 24'hAA55AA);
    send_item(prup_pkg::CMD_LOAD, 24'h123456);
    send_item(prup_pkg::CMD_LOAD, 24'hFEDCBA);
    repeat (5) send_item(prup_pkg::CMD_REQUEST, 24'($urandom()));
    settle();
    program_regs(13'd1, 13'd2, 13'd2);
    empty_row();

    tx_idle_pct = 31;
    rx_idle_pct = 80;
    repeat (4) random_group(22);
    tx_idle_pct = 80;
    rx_idle_pct = 31;
    repeat (4) random_group(22);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (4) random_group(22);

    // long receiver hold so the output queue backs up into in_stall
    empty_row();
    settle();
    program_regs(13'd3, 13'd4, 13'd3);
    fill_row();
    hold_request = 60;
    repeat (10) send_item(prup_pkg::CMD_REQUEST, 24'($urandom()));
    settle();
    empty_row();

    // largest scale: 127 clamps to 99, so the 99th copy ends the output row
    settle();
    program_regs(13'h1FFF, 13'd1, 13'd1);
    fill_row();
    repeat (100) send_item(prup_pkg::CMD_REQUEST, 24'($urandom()));
    settle();
    program_regs(13'd1, 13'd1, 13'd1);
    empty_row();

    // largest width (8191 clamps to 4096), row then cut short by a narrower width
    settle();
    program_regs(13'd1, 13'h1FFF, 13'h1FFF);
    repeat (5) send_item(prup_pkg::CMD_LOAD, 24'($urandom()));
    settle();
    program_regs(13'd1, 13'd3, 13'd2);
    fill_row();
    empty_row();

    settle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d loads and %0d served requests over %0d register settings;",
             sb.loads, sb.requests, sb.settings);
    $display("%0d pixels checked, %0d row ends, %0d frame ends, %0d errors.",
             sb.checked, sb.row_ends, sb.frame_ends, sb.errors);
    if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
